/* src/per_target_command_queue_rr_unit_assert.svh */
// assertion macros used by the checker file
// no dependencies; plain concurrent assertion wrappers
`ifndef PER_TARGET_COMMAND_QUEUE_RR_UNIT_ASSERT_SVH
`define PER_TARGET_COMMAND_QUEUE_RR_UNIT_ASSERT_SVH

// assertion checked only outside reset
`define PTCQ_ASSERT(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// assertion that is also checked during reset
`define PTCQ_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/ptcq_pkg.sv */
// package for the per-target command queue: sizes, command codes, types, helpers
// no dependencies
`timescale 1ns / 1ps

package ptcq_pkg;

  // sizing
  localparam int NUM_TARGETS = 16;
  localparam int QUEUE_DEPTH = 4;

  localparam int TGT_W    = $clog2(NUM_TARGETS);
  localparam int PTR_W    = $clog2(QUEUE_DEPTH);
  localparam int FILL_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int ENTRY_AW = $clog2(NUM_TARGETS * QUEUE_DEPTH);

  // field widths
  localparam int CMD_W   = 2;
  localparam int ID_W    = 8;
  localparam int TYPE_W  = 8;
  localparam int PAY_W   = 48;
  localparam int ENTRY_W = TYPE_W + PAY_W;
  localparam int RETRY_W = 8;
  localparam int TIX_W   = 4;

  localparam logic [RETRY_W-1:0] RETRY_RESET = RETRY_W'(3);

  // command codes
  localparam logic [CMD_W-1:0] CMD_PUSH    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PEEK    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CONSUME = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd3;

  // per-target queue control word
  typedef struct packed {
    logic [PTR_W-1:0]   head;
    logic [PTR_W-1:0]   tail;
    logic [FILL_W-1:0]  fill;
    logic [RETRY_W-1:0] retries;
  } ctrl_t;

  localparam int CTRL_W = $bits(ctrl_t);

  // round-robin pick result
  typedef struct packed {
    logic             found;
    logic [TGT_W-1:0] target;
  } pick_t;

  // flat entry address of slot p in target t's queue
  function automatic logic [ENTRY_AW-1:0] entry_addr(input logic [TGT_W-1:0] t,
                                                     input logic [PTR_W-1:0] p);
    return ENTRY_AW'(t) * ENTRY_AW'(QUEUE_DEPTH) + ENTRY_AW'(p);
  endfunction

  // queue pointer increment with wrap
  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // target increment with wrap
  function automatic logic [TGT_W-1:0] next_tgt(input logic [TGT_W-1:0] t);
    return (t == TGT_W'(NUM_TARGETS - 1)) ? '0 : t + 1'b1;
  endfunction

endpackage

/* src/ptcq_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module ptcq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* src/ptcq_rr_pick.sv */
// round-robin search for the first non-empty queue at or after the cursor
// depends on ptcq_pkg
`timescale 1ns / 1ps

module ptcq_rr_pick (
  input  logic [ptcq_pkg::NUM_TARGETS-1:0] pending,
  input  logic [ptcq_pkg::TGT_W-1:0]       cursor,
  output ptcq_pkg::pick_t                  pick
);

  logic [ptcq_pkg::NUM_TARGETS-1:0] upper;
  logic [ptcq_pkg::TGT_W-1:0]       hi_idx;
  logic [ptcq_pkg::TGT_W-1:0]       lo_idx;

  // pending queues at or above the cursor
  always_comb begin
    for (int i = 0; i < ptcq_pkg::NUM_TARGETS; i++) begin
      upper[i] = pending[i] && (ptcq_pkg::TGT_W'(i) >= cursor);
    end
  end

  // lowest set bit of each vector
  always_comb begin
    hi_idx = '0;
    lo_idx = '0;
    for (int i = ptcq_pkg::NUM_TARGETS - 1; i >= 0; i--) begin
      if (upper[i]) begin
        hi_idx = ptcq_pkg::TGT_W'(i);
      end
      if (pending[i]) begin
        lo_idx = ptcq_pkg::TGT_W'(i);
      end
    end
  end

  // wrap to the bottom when nothing is pending above the cursor
  assign pick.found  = |pending;
  assign pick.target = (|upper) ? hi_idx : lo_idx;

endmodule

/* src/per_target_command_queue_rr_unit.sv */
// top level of the per-target command queue with round-robin peek and retransmit budget
// depends on ptcq_pkg, ptcq_ram, ptcq_rr_pick
`timescale 1ns / 1ps

// One command is taken when start is high and busy is low. All commands but a found
// peek end in the control state; a found peek then reads the head entry from the entry
// ram in the entry state. Each command reads its target's control word from a small
// ram; one that changes it writes it back in the next cycle. The result shows on the
// out_ ports for exactly one cycle with out_strobe high and the receiver cannot stall
// it; a new command may start in that same cycle. The user must write retransmit_count
// through cfg_we/cfg_wdata only while the block is idle; the block does not enforce it.
module per_target_command_queue_rr_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [ptcq_pkg::CMD_W-1:0]    in_cmd,
  input  logic [ptcq_pkg::ID_W-1:0]     in_tracker_id,
  input  logic [ptcq_pkg::TYPE_W-1:0]   in_cmd_type,
  input  logic [ptcq_pkg::PAY_W-1:0]    in_payload,
  input  logic                          cfg_we,
  input  logic [ptcq_pkg::RETRY_W-1:0]  cfg_wdata,
  output logic                          out_strobe,
  output logic                          out_status,
  output logic                          out_found,
  output logic [ptcq_pkg::TIX_W-1:0]    out_target_index,
  output logic [ptcq_pkg::TYPE_W-1:0]   out_type,
  output logic [ptcq_pkg::PAY_W-1:0]    out_payload
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CTRL  = 2'd1;
  localparam logic [1:0] S_ENTRY = 2'd2;

  logic [1:0] state_r, state_nxt;

  // captured command
  logic [ptcq_pkg::CMD_W-1:0]  op_r;
  logic [ptcq_pkg::TGT_W-1:0]  tgt_r;
  logic                        oor_r;
  logic                        found_r;
  logic [ptcq_pkg::TYPE_W-1:0] type_r;
  logic [ptcq_pkg::PAY_W-1:0]  pay_r;

  // persistent control
  logic [ptcq_pkg::RETRY_W-1:0]     retry_cfg_r;
  logic [ptcq_pkg::TGT_W-1:0]       rr_r, rr_nxt;
  logic [ptcq_pkg::NUM_TARGETS-1:0] pending_r;
  logic [ptcq_pkg::NUM_TARGETS-1:0] ctrl_vld_r;

  // result register
  logic                         res_strobe_r;
  logic                         res_status_r;
  logic                         res_found_r;
  logic [ptcq_pkg::TIX_W-1:0]   res_tix_r;
  logic [ptcq_pkg::TYPE_W-1:0]  res_type_r;
  logic [ptcq_pkg::PAY_W-1:0]   res_pay_r;

  logic                         res_ld;
  logic                         res_status;
  logic                         res_found;
  logic [ptcq_pkg::TIX_W-1:0]   res_tix;
  logic [ptcq_pkg::TYPE_W-1:0]  res_type;
  logic [ptcq_pkg::PAY_W-1:0]   res_pay;

  // ram ports
  logic                            ctrl_we;
  logic [ptcq_pkg::CTRL_W-1:0]     ctrl_rdata;
  logic [ptcq_pkg::TGT_W-1:0]      ctrl_raddr;
  ptcq_pkg::ctrl_t                 ctrl_rd;
  ptcq_pkg::ctrl_t                 ctrl_wr;
  logic                            ent_we;
  logic                            ent_re;
  logic [ptcq_pkg::ENTRY_AW-1:0]   ent_waddr;
  logic [ptcq_pkg::ENTRY_AW-1:0]   ent_raddr;
  logic [ptcq_pkg::ENTRY_W-1:0]    ent_rdata;

  // misc
  logic                            accept;
  logic                            in_oor;
  ptcq_pkg::pick_t                 pick;
  logic                            pend_set;
  logic                            pend_clr;
  logic [ptcq_pkg::RETRY_W-1:0]    budget;
  logic [ptcq_pkg::RETRY_W-1:0]    left;

  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);
  assign in_oor = {1'b0, in_tracker_id} >= (ptcq_pkg::ID_W + 1)'(ptcq_pkg::NUM_TARGETS);

  // round-robin search over the pending flags
  ptcq_rr_pick u_pick (
    .pending (pending_r),
    .cursor  (rr_r),
    .pick    (pick)
  );

  // control word read address: peek follows the search, others the tracker id
  assign ctrl_raddr = (in_cmd == ptcq_pkg::CMD_PEEK) ? pick.target
                                                      : in_tracker_id[ptcq_pkg::TGT_W-1:0];

  ptcq_ram #(
    .WIDTH (ptcq_pkg::CTRL_W),
    .DEPTH (ptcq_pkg::NUM_TARGETS)
  ) u_ctrl_ram (
    .clk   (clk),
    .we    (ctrl_we),
    .waddr (tgt_r),
    .wdata (ctrl_wr),
    .re    (accept),
    .raddr (ctrl_raddr),
    .rdata (ctrl_rdata)
  );

  ptcq_ram #(
    .WIDTH (ptcq_pkg::ENTRY_W),
    .DEPTH (ptcq_pkg::NUM_TARGETS * ptcq_pkg::QUEUE_DEPTH)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata ({type_r, pay_r}),
    .re    (ent_re),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

  // a control word never written reads as all zero
  assign ctrl_rd = ctrl_vld_r[tgt_r] ? ptcq_pkg::ctrl_t'(ctrl_rdata) : '0;

  // retransmit budget: reload when exhausted, a zero setting counts as one
  always_comb begin
    if (ctrl_rd.retries != '0) begin
      budget = ctrl_rd.retries;
    end else if (retry_cfg_r != '0) begin
      budget = retry_cfg_r;
    end else begin
      budget = ptcq_pkg::RETRY_W'(1);
    end
    left = budget - 1'b1;
  end

  assign ent_waddr = ptcq_pkg::entry_addr(tgt_r, ctrl_rd.tail);
  assign ent_raddr = ptcq_pkg::entry_addr(tgt_r, ctrl_rd.head);

  // sequencer and read-modify-write of the control word
  always_comb begin
    state_nxt  = state_r;
    ctrl_we    = 1'b0;
    ctrl_wr    = ctrl_rd;
    ent_we     = 1'b0;
    ent_re     = 1'b0;
    pend_set   = 1'b0;
    pend_clr   = 1'b0;
    rr_nxt     = rr_r;
    res_ld     = 1'b0;
    res_status = 1'b0;
    res_found  = 1'b0;
    res_tix    = '0;
    res_type   = '0;
    res_pay    = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_CTRL;
        end
      end
      S_CTRL: begin
        state_nxt = S_IDLE;
        if (op_r == ptcq_pkg::CMD_PEEK) begin
          if (found_r) begin
            ent_re    = 1'b1;
            state_nxt = S_ENTRY;
          end else begin
            res_ld = 1'b1;
          end
        end else if (oor_r) begin
          res_ld     = 1'b1;
          res_status = 1'b1;
        end else begin
          res_ld = 1'b1;
          unique case (op_r)
            ptcq_pkg::CMD_PUSH: begin
              if (ctrl_rd.fill >= ptcq_pkg::FILL_W'(ptcq_pkg::QUEUE_DEPTH)) begin
                res_status = 1'b1;
              end else begin
                ent_we       = 1'b1;
                ctrl_we      = 1'b1;
                ctrl_wr.tail = ptcq_pkg::next_ptr(ctrl_rd.tail);
                ctrl_wr.fill = ctrl_rd.fill + 1'b1;
                pend_set     = 1'b1;
              end
            end
            ptcq_pkg::CMD_CONSUME: begin
              if (ctrl_rd.fill != '0) begin
                ctrl_we         = 1'b1;
                ctrl_wr.retries = left;
                rr_nxt          = ptcq_pkg::next_tgt(tgt_r);
                if (left == '0) begin
                  ctrl_wr.head = ptcq_pkg::next_ptr(ctrl_rd.head);
                  ctrl_wr.fill = ctrl_rd.fill - 1'b1;
                  pend_clr     = (ctrl_rd.fill == ptcq_pkg::FILL_W'(1));
                end
              end
            end
            default: begin
              // clear
              ctrl_we  = 1'b1;
              ctrl_wr  = '0;
              pend_clr = 1'b1;
            end
          endcase
        end
      end
      S_ENTRY: begin
        state_nxt = S_IDLE;
        res_ld    = 1'b1;
        res_found = 1'b1;
        res_tix   = ptcq_pkg::TIX_W'(tgt_r);
        res_type  = ent_rdata[ptcq_pkg::ENTRY_W-1 -: ptcq_pkg::TYPE_W];
        res_pay   = ent_rdata[ptcq_pkg::PAY_W-1:0];
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      retry_cfg_r  <= ptcq_pkg::RETRY_RESET;
      rr_r         <= '0;
      pending_r    <= '0;
      ctrl_vld_r   <= '0;
      res_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      rr_r         <= rr_nxt;
      res_strobe_r <= res_ld;
      if (cfg_we) begin
        retry_cfg_r <= cfg_wdata;
      end
      if (ctrl_we) begin
        ctrl_vld_r[tgt_r] <= 1'b1;
      end
      if (pend_set) begin
        pending_r[tgt_r] <= 1'b1;
      end else if (pend_clr) begin
        pending_r[tgt_r] <= 1'b0;
      end
    end
  end

  // command capture on transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= in_cmd;
      oor_r   <= in_oor;
      found_r <= pick.found;
      type_r  <= in_cmd_type;
      pay_r   <= in_payload;
      tgt_r   <= ctrl_raddr;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (res_ld) begin
      res_status_r <= res_status;
      res_found_r  <= res_found;
      res_tix_r    <= res_tix;
      res_type_r   <= res_type;
      res_pay_r    <= res_pay;
    end
  end

  assign out_strobe       = res_strobe_r;
  assign out_status       = res_status_r;
  assign out_found        = res_found_r;
  assign out_target_index = res_tix_r;
  assign out_type         = res_type_r;
  assign out_payload      = res_pay_r;

endmodule

/* src/ptcq_checker.sv */
// port-level checker for the per-target command queue, bound to the top level
// depends on per_target_command_queue_rr_unit_assert.svh
`timescale 1ns / 1ps
`include "per_target_command_queue_rr_unit_assert.svh"

module ptcq_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_strobe,
  input logic out_status,
  input logic out_found
);

  // a transfer always makes the block busy in the next cycle
  `PTCQ_ASSERT(a_accept_busy, clk, rst_n, (start && !busy) |=> busy, "transfer did not set busy")

  // a result is never shown while a command is still at work
  `PTCQ_ASSERT(a_strobe_idle, clk, rst_n, out_strobe |-> !busy, "result shown while busy")

  // results never come back to back
  `PTCQ_ASSERT(a_strobe_gap, clk, rst_n, out_strobe |=> !out_strobe, "back to back results")

  // a found peek is never rejected
  `PTCQ_ASSERT(a_found_ok, clk, rst_n, (out_strobe && out_found) |-> !out_status,
               "found result with reject status")

  // reset leaves the block idle with no result
  `PTCQ_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> (!busy && !out_strobe),
                      "not idle after reset")

endmodule

bind per_target_command_queue_rr_unit ptcq_checker u_ptcq_checker (.*);

/* tb/tb_top.sv */
// self-checking testbench for per_target_command_queue_rr_unit: directed and random commands
// depends on ptcq_pkg and the rtl top level; predicts every response with its own queue model
`timescale 1ns / 1ps

import ptcq_pkg::*;

// one response as seen on the out_ ports
typedef struct packed {
  logic               status;
  logic               found;
  logic [TIX_W-1:0]   target;
  logic [TYPE_W-1:0]  ctype;
  logic [PAY_W-1:0]   payload;
} response_t;

class queue_scoreboard;
  // mirrored queue state
  logic [ENTRY_W-1:0] entries [NUM_TARGETS][QUEUE_DEPTH];
  logic [PTR_W-1:0]   head    [NUM_TARGETS];
  logic [PTR_W-1:0]   tail    [NUM_TARGETS];
  logic [FILL_W-1:0]  fill    [NUM_TARGETS];
  logic [RETRY_W-1:0] retries [NUM_TARGETS];
  logic [TGT_W-1:0]   scan_start;
  logic [RETRY_W-1:0] budget;

  response_t pending_responses[$];
  int unsigned mismatches;
  int unsigned responses_seen;

  function new();
    for (int t = 0; t < NUM_TARGETS; t++) begin
      for (int p = 0; p < QUEUE_DEPTH; p++) entries[t][p] = '0;
      head[t]    = '0;
      tail[t]    = '0;
      fill[t]    = '0;
      retries[t] = '0;
    end
    scan_start     = '0;
    budget         = RETRY_RESET;
    mismatches     = 0;
    responses_seen = 0;
  endfunction

  function void set_budget(logic [RETRY_W-1:0] value);
    budget = value;
  endfunction

  function int unsigned outstanding();
    return pending_responses.size();
  endfunction

  task report_mismatch(string what);
    mismatches++;
    if (mismatches <= 40) $display("mismatch at %0t ns: %s", $time, what);
  endtask

  // update the queue model for one accepted command and return its response
  function response_t apply_command(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] tid,
                                    logic [TYPE_W-1:0] ctype, logic [PAY_W-1:0] pay);
    response_t r;
    int unsigned t;
    logic [ENTRY_W-1:0] e;
    r = '0;
    if (cmd == CMD_PEEK) begin
      // scan from the cursor, first non-empty queue wins
      for (int i = 0; i < NUM_TARGETS; i++) begin
        t = (scan_start + i) % NUM_TARGETS;
        if (!r.found && fill[t] != 0) begin
          e         = entries[t][head[t]];
          r.found   = 1'b1;
          r.target  = TIX_W'(t);
          r.ctype   = e[ENTRY_W-1:PAY_W];
          r.payload = e[PAY_W-1:0];
        end
      end
    end else if (tid >= NUM_TARGETS) begin
      r.status = 1'b1;
    end else begin
      case (cmd)
        CMD_PUSH: begin
          if (fill[tid] >= QUEUE_DEPTH) begin
            r.status = 1'b1;
          end else begin
            entries[tid][tail[tid]] = {ctype, pay};
            tail[tid] = PTR_W'((tail[tid] + 1) % QUEUE_DEPTH);
            fill[tid] = fill[tid] + 1'b1;
          end
        end
        CMD_CONSUME: begin
          // empty queue leaves everything alone, cursor included
          if (fill[tid] != 0) begin
            if (retries[tid] == 0) retries[tid] = (budget == 0) ? RETRY_W'(1) : budget;
            retries[tid] = retries[tid] - 1'b1;
            if (retries[tid] == 0) begin
              head[tid] = PTR_W'((head[tid] + 1) % QUEUE_DEPTH);
              fill[tid] = fill[tid] - 1'b1;
            end
            scan_start = TGT_W'((tid + 1) % NUM_TARGETS);
          end
        end
        CMD_CLEAR: begin
          head[tid]    = '0;
          tail[tid]    = '0;
          fill[tid]    = '0;
          retries[tid] = '0;
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  function void note_command(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] tid,
                             logic [TYPE_W-1:0] ctype, logic [PAY_W-1:0] pay);
    pending_responses.push_back(apply_command(cmd, tid, ctype, pay));
  endfunction

  // compare one response with the oldest prediction
  task check_response(response_t got);
    response_t want;
    if (pending_responses.size() == 0) begin
      report_mismatch("response with no command outstanding");
    end else begin
      want = pending_responses.pop_front();
      if (got.status !== want.status)
        report_mismatch($sformatf("response %0d status got %0b want %0b",
                                  responses_seen, got.status, want.status));
      if (got.found !== want.found)
        report_mismatch($sformatf("response %0d found got %0b want %0b",
                                  responses_seen, got.found, want.found));
      if (got.target !== want.target)
        report_mismatch($sformatf("response %0d target got %0d want %0d",
                                  responses_seen, got.target, want.target));
      if (got.ctype !== want.ctype)
        report_mismatch($sformatf("response %0d type got %h want %h",
                                  responses_seen, got.ctype, want.ctype));
      if (got.payload !== want.payload)
        report_mismatch($sformatf("response %0d payload got %h want %h",
                                  responses_seen, got.payload, want.payload));
    end
    responses_seen++;
  endtask
endclass

module tb_top;
  logic                clk;
  logic                rst_n         = 1'b0;
  logic                start         = 1'b0;
  logic                busy;
  logic [CMD_W-1:0]    in_cmd        = CMD_PEEK;
  logic [ID_W-1:0]     in_tracker_id = '0;
  logic [TYPE_W-1:0]   in_cmd_type   = '0;
  logic [PAY_W-1:0]    in_payload    = '0;
  logic                cfg_we        = 1'b0;
  logic [RETRY_W-1:0]  cfg_wdata     = '0;
  logic                out_strobe;
  logic                out_status;
  logic                out_found;
  logic [TIX_W-1:0]    out_target_index;
  logic [TYPE_W-1:0]   out_type;
  logic [PAY_W-1:0]    out_payload;

  queue_scoreboard sb = new();

  per_target_command_queue_rr_unit u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_cmd           (in_cmd),
    .in_tracker_id    (in_tracker_id),
    .in_cmd_type      (in_cmd_type),
    .in_payload       (in_payload),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .out_strobe       (out_strobe),
    .out_status       (out_status),
    .out_found        (out_found),
    .out_target_index (out_target_index),
    .out_type         (out_type),
    .out_payload      (out_payload)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  initial begin
    #3000000;
    $display("Regression FAIL");
    $finish;
  end

  // response monitor
  always @(posedge clk) begin
    if (rst_n && out_strobe)
      sb.check_response({out_status, out_found, out_target_index, out_type, out_payload});
  end

  // drive one command and hold it until the block takes it
  task automatic send_command(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] tid,
                              logic [TYPE_W-1:0] ctype, logic [PAY_W-1:0] pay);
    start         <= 1'b1;
    in_cmd        <= cmd;
    in_tracker_id <= tid;
    in_cmd_type   <= ctype;
    in_payload    <= pay;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_command(cmd, tid, ctype, pay);
  endtask

  // random sender gap, geometric in length
  task automatic sender_pause(int unsigned pct);
    int unsigned gap;
    gap = 0;
    while (pct != 0 && gap < 12 && $urandom_range(99) < pct) gap++;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop sending until every response is back, then let the block settle
  task automatic wait_for_responses();
    start <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_budget(logic [RETRY_W-1:0] value);
    wait_for_responses();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_budget(value);
  endtask

  // one random command: mostly in-range targets from a window, some noise
  task automatic random_command(int unsigned base, int unsigned span);
    logic [CMD_W-1:0]  cmd;
    logic [ID_W-1:0]   tid;
    logic [TYPE_W-1:0] ctype;
    logic [PAY_W-1:0]  pay;
    int unsigned       pick;
    ctype = TYPE_W'($urandom);
    pay   = {16'($urandom), 32'($urandom)};
    pick  = $urandom_range(99);
    if (pick < 4) pay = '0;
    else if (pick < 8) pay = '1;
    if ($urandom_range(99) < 8) begin
      cmd = CMD_W'($urandom);
      tid = ID_W'($urandom);
    end else begin
      pick = $urandom_range(99);
      if (pick < 40) cmd = CMD_PUSH;
      else if (pick < 65) cmd = CMD_PEEK;
      else if (pick < 93) cmd = CMD_CONSUME;
      else cmd = CMD_CLEAR;
      tid = ID_W'((base + $urandom_range(span - 1)) % NUM_TARGETS);
    end
    send_command(cmd, tid, ctype, pay);
  endtask

  logic [RETRY_W-1:0] phase_budget [6] = '{8'd1, 8'd255, 8'd3, 8'd0, 8'd2, 8'd200};
  int unsigned        phase_idle   [6] = '{0, 55, 0, 27, 55, 27};
  int unsigned        phase_span   [6] = '{16, 3, 4, 2, 16, 5};

  initial begin
    int unsigned wait_cycles;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty queues, out-of-range targets, full queue, cursor moves
    send_command(CMD_PEEK,    8'd0,   8'h00, 48'h0);
    send_command(CMD_CONSUME, 8'd0,   8'h00, 48'h0);
    send_command(CMD_PUSH,    8'd255, 8'hff, '1);
    send_command(CMD_CONSUME, 8'd16,  8'h00, 48'h0);
    send_command(CMD_CLEAR,   8'd128, 8'h00, 48'h0);
    send_command(CMD_PUSH,    8'd15,  8'h00, 48'h0);
    send_command(CMD_PUSH,    8'd15,  8'hff, '1);
    send_command(CMD_PUSH,    8'd15,  8'ha5, 48'h5555_5555_5555);
    send_command(CMD_PUSH,    8'd15,  8'h5a, 48'haaaa_aaaa_aaaa);
    send_command(CMD_PUSH,    8'd15,  8'h11, 48'h1234_5678_9abc);
    send_command(CMD_PUSH,    8'd0,   8'h01, 48'h1);
    send_command(CMD_PEEK,    8'd0,   8'h00, 48'h0);
    send_command(CMD_CONSUME, 8'd15,  8'h00, 48'h0);
    send_command(CMD_CONSUME, 8'd0,   8'h00, 48'h0);
    send_command(CMD_PEEK,    8'd0,   8'h00, 48'h0);
    send_command(CMD_CONSUME, 8'd15,  8'h00, 48'h0);
    send_command(CMD_CONSUME, 8'd15,  8'h00, 48'h0);
    send_command(CMD_PEEK,    8'd255, 8'h00, 48'h0);
    send_command(CMD_CLEAR,   8'd15,  8'h00, 48'h0);
    send_command(CMD_CONSUME, 8'd15,  8'h00, 48'h0);
    send_command(CMD_PEEK,    8'd0,   8'h00, 48'h0);
    // zero budget pops on the first consume
    write_budget(8'd0);
    send_command(CMD_PUSH,    8'd3,   8'h33, 48'hc0de_0000_0003);
    send_command(CMD_CONSUME, 8'd3,   8'h00, 48'h0);
    send_command(CMD_PEEK,    8'd0,   8'h00, 48'h0);

    // random phases, each with its own budget, idle rate and target window
    for (int ph = 0; ph < 6; ph++) begin
      write_budget(phase_budget[ph]);
      for (int n = 0; n < 255; n++) begin
        if (n == 128) wait_for_responses();
        sender_pause(phase_idle[ph]);
        random_command($urandom_range(NUM_TARGETS - 1), phase_span[ph]);
      end
    end

    // drain and let any stray response show up
    start <= 1'b0;
    wait_cycles = 0;
    while (sb.outstanding() != 0 && wait_cycles < 200) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (10) @(posedge clk);
    if (sb.outstanding() != 0)
      sb.report_mismatch($sformatf("%0d responses never arrived", sb.outstanding()));

    if (sb.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

/* sim.f */
+incdir+src
src/ptcq_pkg.sv
src/ptcq_ram.sv
src/ptcq_rr_pick.sv
src/per_target_command_queue_rr_unit.sv
src/ptcq_checker.sv
tb/tb_top.sv
